// ===== sv/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types and constants for the rotary knob controller.
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int unsigned MaxLevelReset = 16;

    typedef enum logic [2:0] {
        CMD_PIN_CHANGE = 3'd0,
        CMD_MODE_SET   = 3'd1,
        CMD_MODE_INC   = 3'd2,
        CMD_MODE_DEC   = 3'd3,
        CMD_LEVEL_SET  = 3'd4,
        CMD_LEVEL_INC  = 3'd5,
        CMD_LEVEL_DEC  = 3'd6,
        CMD_REPORT     = 3'd7
    } t_cmd;

    localparam logic signed [1:0] DirNone = 2'sb00;
    localparam logic signed [1:0] DirUp   = 2'sb01;
    localparam logic signed [1:0] DirDown = 2'sb11;

    typedef struct packed {
        logic [7:0] new_value;
        logic [1:0] encoder_ab;
        logic       button_down;
        t_cmd       command;
    } t_item;

    typedef struct packed {
        logic                    detent_up;
        logic                    detent_down;
        logic signed [2:0]       step_count;
    } t_quad;

    typedef struct packed {
        logic                    is_report;
        logic signed [1:0]       direction;
        logic [7:0]              level;
        logic [7:0]              mode;
    } t_result;

endpackage

// ===== sv/rotary_knob_controller.sv =====
// ----------------------------------------------------------------------------
// rotary_knob_controller
// Quadrature knob decoder with detent counting, mode selector and clamped
// level, driven by pin-change items and host commands.
//
//   Channel  Dir  Bus fields (low bit first)
//   s        in   tuser: command[2:0]; tdata: button_down, encoder_ab, new_value
//   m        out  tuser: is_report; tdata: mode, level, direction
//   cfg      in   i_cfg_wen / i_cfg_wdata: max_level
//
// One item per cycle while the output is not stalled; an accepted input passes the
// input register, then the result register, before its result can be accepted.
// The state update and result share one combinational path between the registers.
// Synchronous active-low reset; max_level resets to 16, knob state and valid flags to zero.
// A stalled output holds its result while the input register still takes
// one more item.
// ----------------------------------------------------------------------------
module rotary_knob_controller
    import rkc_pkg::*;
#(
    parameter int unsigned MODE_COUNT = 8
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // button_down, encoder_ab[1:0], new_value[7:0]
    input  logic [2:0]  i_s_tuser,   // command[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // mode[7:0], level[7:0], direction[1:0]
    output logic        o_m_tuser    // is_report
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    advance;
    t_result core_result;
    t_result out_result;
    logic    out_valid;

    assign advance    = r_in_valid && (!out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.command     <= t_cmd'(i_s_tuser);
            r_in_item.button_down <= i_s_tdata[0];
            r_in_item.encoder_ab  <= i_s_tdata[2:1];
            r_in_item.new_value   <= i_s_tdata[10:3];
        end
    end

    rkc_core #(
        .MODE_COUNT (MODE_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_item      (r_in_item),
        .o_result    (core_result)
    );

    rkc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_take   (i_m_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {6'd0, out_result.direction, out_result.level, out_result.mode};
    assign o_m_tuser  = out_result.is_report;

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input item dropped while stalled");

    a_ready_means_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && out_valid && !i_m_tready)
        else $error("input stalled without a blocked result");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_tvalid)
        else $error("processed item produced no result");
`endif

endmodule

// ===== sv/rkc_quad.sv =====
// ----------------------------------------------------------------------------
// rkc_quad
// Quadrature step decode and detent accumulation.
// ----------------------------------------------------------------------------
module rkc_quad
    import rkc_pkg::*;
(
    input  logic [1:0]        i_prev_ab,
    input  logic [1:0]        i_ab,
    input  logic signed [2:0] i_step_count,
    output t_quad             o_quad
);

    logic signed [3:0] step;
    logic signed [3:0] sum;
    logic              up;
    logic              down;

    always_comb begin
        case ({i_prev_ab, i_ab})
            4'b1101, 4'b0100, 4'b0010, 4'b1011: begin
                step = -4'sd1;
            end
            4'b1110, 4'b1000, 4'b0001, 4'b0111: begin
                step = 4'sd1;
            end
            default: begin
                step = 4'sd0;
            end
        endcase
    end

    assign sum  = 4'({i_step_count[2], i_step_count}) + step;
    assign up   = (sum == 4'sd4);
    assign down = (sum == -4'sd4);

    assign o_quad.detent_up   = up;
    assign o_quad.detent_down = down;
    assign o_quad.step_count  = (up || down) ? 3'sd0 : sum[2:0];

endmodule

// ===== sv/rkc_core.sv =====
// ----------------------------------------------------------------------------
// rkc_core
// Knob state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module rkc_core
    import rkc_pkg::*;
#(
    parameter int unsigned MODE_COUNT = 8
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_advance,
    input  t_item      i_item,
    output t_result    o_result
);

    logic [7:0]        r_max_level;
    logic [7:0]        r_mode;
    logic [7:0]        r_level;
    logic signed [1:0] r_pending_dir;
    logic signed [2:0] r_step_count;
    logic [1:0]        r_prev_ab;

    logic [7:0]        n_mode;
    logic [7:0]        n_level;
    logic signed [1:0] n_pending_dir;
    logic signed [2:0] n_step_count;
    logic [1:0]        n_prev_ab;

    logic [7:0]        mode_inc_tab [256];
    logic [7:0]        mode_dec_tab [256];
    logic [7:0]        level_inc;
    logic [7:0]        level_dec;
    logic              report;
    t_quad             quad;

    for (genvar g = 0; g < 256; g++) begin : g_mode_tab
        assign mode_inc_tab[g] = 8'((g + 1) % MODE_COUNT);
        if (g == 0) begin : g_zero
            assign mode_dec_tab[g] = 8'(MODE_COUNT - 1);
        end else begin : g_other
            assign mode_dec_tab[g] = 8'((g - 1) % MODE_COUNT);
        end
    end

    rkc_quad u_quad (
        .i_prev_ab    (r_prev_ab),
        .i_ab         (i_item.encoder_ab),
        .i_step_count (r_step_count),
        .o_quad       (quad)
    );

    assign level_inc = (r_level < r_max_level) ? r_level + 8'd1 : r_level;
    assign level_dec = (r_level != 8'd0) ? r_level - 8'd1 : r_level;

    always_comb begin
        n_mode        = r_mode;
        n_level       = r_level;
        n_pending_dir = r_pending_dir;
        n_step_count  = r_step_count;
        n_prev_ab     = r_prev_ab;
        report        = 1'b0;
        case (i_item.command)
            CMD_PIN_CHANGE: begin
                if (i_item.button_down) begin
                    n_mode = mode_inc_tab[r_mode];
                end else begin
                    n_prev_ab    = i_item.encoder_ab;
                    n_step_count = quad.step_count;
                    if (quad.detent_up) begin
                        n_pending_dir = DirUp;
                        n_level       = level_inc;
                    end else if (quad.detent_down) begin
                        n_pending_dir = DirDown;
                        n_level       = level_dec;
                    end
                end
            end
            CMD_MODE_SET: begin
                n_mode = i_item.new_value;
            end
            CMD_MODE_INC: begin
                n_mode = mode_inc_tab[r_mode];
            end
            CMD_MODE_DEC: begin
                n_mode = mode_dec_tab[r_mode];
            end
            CMD_LEVEL_SET: begin
                n_level = i_item.new_value;
            end
            CMD_LEVEL_INC: begin
                n_level = level_inc;
            end
            CMD_LEVEL_DEC: begin
                n_level = level_dec;
            end
            CMD_REPORT: begin
                report        = 1'b1;
                n_pending_dir = DirNone;
            end
            default: begin
                report = 1'b0;
            end
        endcase
    end

    assign o_result.mode      = n_mode;
    assign o_result.level     = n_level;
    assign o_result.direction = report ? r_pending_dir : n_pending_dir;
    assign o_result.is_report = report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= 8'(MaxLevelReset);
        end else if (i_cfg_wen) begin
            r_max_level <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_level       <= '0;
            r_pending_dir <= DirNone;
            r_step_count  <= '0;
            r_prev_ab     <= '0;
        end else if (i_advance) begin
            r_mode        <= n_mode;
            r_level       <= n_level;
            r_pending_dir <= n_pending_dir;
            r_step_count  <= n_step_count;
            r_prev_ab     <= n_prev_ab;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_count != -3'sd4)
        else $error("step count left its range");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_dir != 2'sb10)
        else $error("pending direction holds an invalid code");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.command == CMD_REPORT |=> r_pending_dir == DirNone)
        else $error("report did not clear the pending direction");

    a_button_keeps_ab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.command == CMD_PIN_CHANGE && i_item.button_down
        |=> $stable(r_prev_ab) && $stable(r_step_count))
        else $error("button press disturbed the encoder state");
`endif

endmodule

// ===== sv/rkc_out_reg.sv =====
// ----------------------------------------------------------------------------
// rkc_out_reg
// Result register that holds one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module rkc_out_reg
    import rkc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
